// File: sv/cmt_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the congruence merge table
package cmt_pkg;

    // width of one arithmetic word and of an iteration counter over it
    localparam int WORD  = 64;
    localparam int CNT_W = $clog2(WORD);

    localparam logic [63:0] TOP_BIT = 64'h8000_0000_0000_0000;
    localparam logic [63:0] INT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        ST_IGNORED = 3'd0,
        ST_FIRST   = 3'd1,
        ST_CHANGED = 3'd2,
        ST_SAME    = 3'd3,
        ST_CONTRA  = 3'd4,
        ST_LCM_OVF = 3'd5,
        ST_NO_INV  = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        K_OOB,
        K_IGN,
        K_WORK
    } t_kind;

    typedef struct packed {
        logic [5:0]         var_slot;
        logic signed [63:0] new_modulus;
        logic signed [63:0] new_residue;
    } t_cmd;

    typedef struct packed {
        t_status     status;
        logic [62:0] stored_modulus;
        logic [62:0] stored_residue;
        logic        contradiction;
    } t_result;

    typedef struct packed {
        t_kind kind;
        t_cmd  cmd;
    } t_qent;

    typedef struct packed {
        logic clearing;
        logic take;
    } t_back_stat;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_CLS,
        S_RED,
        S_GCD,
        S_CHK,
        S_RDC,
        S_OVF,
        S_STP,
        S_NM,
        S_DG,
        S_DGR,
        S_INV0,
        S_INVD,
        S_INVM,
        S_K,
        S_MRG,
        S_OUT
    } t_bstate;

endpackage

// File: sv/cmt_ram.sv
`timescale 1ns / 1ps
// generic single write port ram with registered read
module cmt_ram #(
    parameter int WIDTH = 126,
    parameter int DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/cmt_divu.sv
`timescale 1ns / 1ps
// iterative restoring divider, one quotient bit per cycle
module cmt_divu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_n,
    input  logic [63:0] i_d,
    output logic        o_done,
    output logic [63:0] o_q,
    output logic [63:0] o_rem
);

    logic                      r_run;
    logic                      r_done;
    logic [cmt_pkg::CNT_W-1:0] r_cnt;
    logic [63:0]               r_rem;
    logic [63:0]               r_quo;
    logic [63:0]               r_d;
    logic [64:0]               trial;
    logic [64:0]               diff;
    logic                      ge;

    // one shift and trial subtract
    always_comb begin
        trial = {r_rem, r_quo[63]};
        diff  = trial - {1'b0, r_d};
        ge    = (trial >= {1'b0, r_d});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_run && (r_cnt == '1);
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_n;
            r_d   <= i_d;
        end else if (r_run) begin
            r_rem <= ge ? diff[63:0] : trial[63:0];
            r_quo <= {r_quo[62:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_q    = r_quo;
    assign o_rem  = r_rem;

endmodule

// File: sv/cmt_mulmod.sv
`timescale 1ns / 1ps
// shift and add modular multiplier, one bit of b per cycle
module cmt_mulmod (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    input  logic [63:0] i_m,
    output logic        o_done,
    output logic [63:0] o_p
);

    logic                      r_run;
    logic                      r_done;
    logic [cmt_pkg::CNT_W-1:0] r_cnt;
    logic [63:0]               r_a;
    logic [63:0]               r_b;
    logic [63:0]               r_m;
    logic [63:0]               r_acc;
    logic [63:0]               acc_s;
    logic [63:0]               a_s;
    logic [63:0]               n_acc;
    logic [63:0]               n_a;

    // conditional add and doubling, each reduced once
    always_comb begin
        acc_s = r_b[0] ? r_acc + r_a : r_acc;
        n_acc = (acc_s >= r_m) ? acc_s - r_m : acc_s;
        a_s   = r_a + r_a;
        n_a   = (a_s >= r_m) ? a_s - r_m : a_s;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_run && (r_cnt == '1);
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_m   <= i_m;
            r_acc <= '0;
        end else if (r_run) begin
            r_acc <= n_acc;
            r_a   <= n_a;
            r_b   <= {1'b0, r_b[63:1]};
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

// File: sv/cmt_front.sv
`timescale 1ns / 1ps
// command intake: classify words and queue them for the merge engine
module cmt_front #(
    parameter int NUM_SLOTS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  cmt_pkg::t_cmd        i_cmd,
    output logic                 o_busy,
    input  cmt_pkg::t_back_stat  i_stat,
    output logic                 o_valid,
    output cmt_pkg::t_qent       o_ent
);

    cmt_pkg::t_qent r_q [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           push;
    logic           pop;
    cmt_pkg::t_kind kind;

    // classify the incoming word
    always_comb begin
        priority if (32'(i_cmd.var_slot) >= 32'(NUM_SLOTS)) begin
            kind = cmt_pkg::K_OOB;
        end else if (i_cmd.new_modulus[63] || (i_cmd.new_modulus == 64'sd0)) begin
            kind = cmt_pkg::K_IGN;
        end else begin
            kind = cmt_pkg::K_WORK;
        end
    end

    // handshake
    assign o_busy  = r_cnt[1] | i_stat.clearing;
    assign o_valid = (r_cnt != 2'd0);
    assign push    = i_start & ~o_busy;
    assign pop     = i_stat.take & o_valid;
    assign o_ent   = r_q[r_rp];

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            unique case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{kind: kind, cmd: i_cmd};
        end
    end

endmodule

// File: sv/cmt_back.sv
`timescale 1ns / 1ps
// merge engine: slot table, gcd, inverse and modular products
module cmt_back #(
    parameter int NUM_SLOTS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  cmt_pkg::t_qent       i_ent,
    output cmt_pkg::t_back_stat  o_stat,
    output logic                 o_done,
    output cmt_pkg::t_result     o_result
);

    localparam int AW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [AW-1:0] LAST = AW'(NUM_SLOTS - 1);

    cmt_pkg::t_bstate r_state, n_state;
    logic             r_wait;
    logic             r_flag;
    logic [AW-1:0]    r_clr_cnt;
    logic             r_done;
    cmt_pkg::t_result r_res;

    logic [AW-1:0]      r_slot;
    cmt_pkg::t_kind     r_kind;
    logic signed [63:0] r_res_in;
    logic [62:0]        r_m, r_r, r_om, r_orr, r_ga, r_gb;
    logic signed [63:0] r_diff;
    logic [62:0]        r_red, r_step, r_nm, r_dgx, r_dg;
    logic [62:0]        r_r0, r_r1, r_t0, r_t1, r_qi, r_r2, r_k;
    cmt_pkg::t_status   r_status;
    logic [62:0]        r_pm, r_pr;

    logic        div_start, div_done, mul_start, mul_done;
    logic        is_div, is_mul;
    logic [63:0] div_n, div_d, div_q, div_rem;
    logic [63:0] mul_a, mul_b, mul_m, mul_p;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [125:0]  ram_wdata, ram_rdata;
    logic [11:0]   in_slot_w;

    logic [62:0] red_res, t2, merged, dg_val, dgx_val;
    logic [63:0] x_chk, abs_diff, sum;
    logic        bad, changed;

    // slot index into table address
    assign in_slot_w  = {6'd0, i_ent.cmd.var_slot};

    // values derived from unit results
    always_comb begin
        red_res  = r_res_in[63] ? (r_m - 63'd1 - div_rem[62:0]) : div_rem[62:0];
        x_chk    = r_diff[63] ? ~r_diff : r_diff;
        abs_diff = r_diff[63] ? -r_diff : r_diff;
        bad      = r_diff[63] ? ((r_ga - 63'd1 - div_rem[62:0]) != 63'd0)
                              : (div_rem[62:0] != 63'd0);
        dgx_val  = r_diff[63] ? (div_q[62:0] - 63'd1) : div_q[62:0];
        dg_val   = r_diff[63] ? (r_red - 63'd1 - div_rem[62:0]) : div_rem[62:0];
        t2       = (r_t0 >= mul_p[62:0]) ? (r_t0 - mul_p[62:0])
                                         : (r_t0 + (r_red - mul_p[62:0]));
        sum      = {1'b0, mul_p[62:0]} + {1'b0, r_orr};
        merged   = (sum >= {1'b0, r_nm}) ? (sum[62:0] - r_nm) : sum[62:0];
        changed  = (r_nm != r_om) || (merged != r_orr);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cmt_pkg::S_CLEAR: if (r_clr_cnt == LAST) n_state = cmt_pkg::S_IDLE;
            cmt_pkg::S_IDLE:  if (i_valid) n_state = cmt_pkg::S_CLS;
            cmt_pkg::S_CLS: begin
                n_state = (r_kind == cmt_pkg::K_WORK) ? cmt_pkg::S_RED : cmt_pkg::S_OUT;
            end
            cmt_pkg::S_RED: begin
                if (div_done) n_state = (r_om == 63'd0) ? cmt_pkg::S_OUT : cmt_pkg::S_GCD;
            end
            cmt_pkg::S_GCD:   if (r_gb == 63'd0) n_state = cmt_pkg::S_CHK;
            cmt_pkg::S_CHK:   if (div_done) n_state = bad ? cmt_pkg::S_OUT : cmt_pkg::S_RDC;
            cmt_pkg::S_RDC:   if (div_done) n_state = cmt_pkg::S_OVF;
            cmt_pkg::S_OVF: begin
                if (div_done) begin
                    n_state = ({1'b0, r_om} > div_q) ? cmt_pkg::S_OUT : cmt_pkg::S_STP;
                end
            end
            cmt_pkg::S_STP:   if (div_done) n_state = cmt_pkg::S_NM;
            cmt_pkg::S_NM: begin
                if (mul_done) n_state = (r_red == 63'd1) ? cmt_pkg::S_MRG : cmt_pkg::S_DG;
            end
            cmt_pkg::S_DG:    if (div_done) n_state = cmt_pkg::S_DGR;
            cmt_pkg::S_DGR:   if (div_done) n_state = cmt_pkg::S_INV0;
            cmt_pkg::S_INV0:  if (div_done) n_state = cmt_pkg::S_INVD;
            cmt_pkg::S_INVD: begin
                if (r_r1 == 63'd0) begin
                    n_state = (r_r0 != 63'd1) ? cmt_pkg::S_OUT : cmt_pkg::S_K;
                end else if (div_done) begin
                    n_state = cmt_pkg::S_INVM;
                end
            end
            cmt_pkg::S_INVM:  if (mul_done) n_state = cmt_pkg::S_INVD;
            cmt_pkg::S_K:     if (mul_done) n_state = cmt_pkg::S_MRG;
            cmt_pkg::S_MRG:   if (mul_done) n_state = cmt_pkg::S_OUT;
            cmt_pkg::S_OUT:   n_state = cmt_pkg::S_IDLE;
            default:          n_state = cmt_pkg::S_IDLE;
        endcase
    end

    // unit operands, unit starts and table access
    always_comb begin
        is_div = 1'b0;
        is_mul = 1'b0;
        div_n  = '0;
        div_d  = '0;
        mul_a  = '0;
        mul_b  = '0;
        mul_m  = '0;
        unique case (r_state)
            cmt_pkg::S_RED: begin
                is_div = 1'b1;
                div_n  = r_res_in[63] ? ~r_res_in : r_res_in;
                div_d  = {1'b0, r_m};
            end
            cmt_pkg::S_GCD: begin
                is_div = (r_gb != 63'd0);
                div_n  = {1'b0, r_ga};
                div_d  = {1'b0, r_gb};
            end
            cmt_pkg::S_CHK: begin
                is_div = 1'b1;
                div_n  = x_chk;
                div_d  = {1'b0, r_ga};
            end
            cmt_pkg::S_RDC: begin
                is_div = 1'b1;
                div_n  = {1'b0, r_m};
                div_d  = {1'b0, r_ga};
            end
            cmt_pkg::S_OVF: begin
                is_div = 1'b1;
                div_n  = cmt_pkg::INT_MAX;
                div_d  = {1'b0, r_red};
            end
            cmt_pkg::S_STP: begin
                is_div = 1'b1;
                div_n  = {1'b0, r_om};
                div_d  = {1'b0, r_ga};
            end
            cmt_pkg::S_DG: begin
                is_div = 1'b1;
                div_n  = abs_diff;
                div_d  = {1'b0, r_ga};
            end
            cmt_pkg::S_DGR: begin
                is_div = 1'b1;
                div_n  = {1'b0, r_dgx};
                div_d  = {1'b0, r_red};
            end
            cmt_pkg::S_INV0: begin
                is_div = 1'b1;
                div_n  = {1'b0, r_step};
                div_d  = {1'b0, r_red};
            end
            cmt_pkg::S_INVD: begin
                is_div = (r_r1 != 63'd0);
                div_n  = {1'b0, r_r0};
                div_d  = {1'b0, r_r1};
            end
            cmt_pkg::S_NM: begin
                is_mul = 1'b1;
                mul_a  = {1'b0, r_step};
                mul_b  = {1'b0, r_m};
                mul_m  = cmt_pkg::TOP_BIT;
            end
            cmt_pkg::S_INVM: begin
                is_mul = 1'b1;
                mul_a  = {1'b0, r_qi};
                mul_b  = {1'b0, r_t1};
                mul_m  = {1'b0, r_red};
            end
            cmt_pkg::S_K: begin
                is_mul = 1'b1;
                mul_a  = {1'b0, r_dg};
                mul_b  = {1'b0, r_t0};
                mul_m  = {1'b0, r_red};
            end
            cmt_pkg::S_MRG: begin
                is_mul = 1'b1;
                mul_a  = (r_om == r_nm) ? 64'd0 : {1'b0, r_om};
                mul_b  = {1'b0, r_k};
                mul_m  = {1'b0, r_nm};
            end
            default: begin
                is_div = 1'b0;
            end
        endcase
        div_start = is_div & ~r_wait;
        mul_start = is_mul & ~r_wait;

        ram_raddr = (r_state == cmt_pkg::S_IDLE) ? in_slot_w[AW-1:0] : r_slot;
        ram_we    = 1'b0;
        ram_waddr = r_slot;
        ram_wdata = '0;
        priority if (r_state == cmt_pkg::S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_cnt;
        end else if ((r_state == cmt_pkg::S_RED) && div_done && (r_om == 63'd0)) begin
            ram_we    = 1'b1;
            ram_wdata = {r_m, red_res};
        end else if ((r_state == cmt_pkg::S_MRG) && mul_done && changed) begin
            ram_we    = 1'b1;
            ram_wdata = {r_nm, merged};
        end else begin
            ram_we    = 1'b0;
        end

        o_stat.clearing = (r_state == cmt_pkg::S_CLEAR);
        o_stat.take     = (r_state == cmt_pkg::S_IDLE);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= cmt_pkg::S_CLEAR;
            r_wait    <= 1'b0;
            r_flag    <= 1'b0;
            r_clr_cnt <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (div_start || mul_start) begin
                r_wait <= 1'b1;
            end else if (div_done || mul_done) begin
                r_wait <= 1'b0;
            end
            if (r_state == cmt_pkg::S_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if ((r_state == cmt_pkg::S_CHK) && div_done && bad) begin
                r_flag <= 1'b1;
            end
            r_done <= (r_state == cmt_pkg::S_OUT);
        end
    end

    // merge datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            cmt_pkg::S_IDLE: begin
                r_slot   <= in_slot_w[AW-1:0];
                r_kind   <= i_ent.kind;
                r_res_in <= i_ent.cmd.new_residue;
                r_m      <= i_ent.cmd.new_modulus[62:0];
            end
            cmt_pkg::S_CLS: begin
                r_om     <= ram_rdata[125:63];
                r_orr    <= ram_rdata[62:0];
                r_status <= cmt_pkg::ST_IGNORED;
                r_pm     <= (r_kind == cmt_pkg::K_OOB) ? 63'd0 : ram_rdata[125:63];
                r_pr     <= (r_kind == cmt_pkg::K_OOB) ? 63'd0 : ram_rdata[62:0];
            end
            cmt_pkg::S_RED: begin
                if (div_done) begin
                    r_r  <= red_res;
                    r_ga <= r_om;
                    r_gb <= r_m;
                    if (r_om == 63'd0) begin
                        r_status <= cmt_pkg::ST_FIRST;
                        r_pm     <= r_m;
                        r_pr     <= red_res;
                    end
                end
            end
            cmt_pkg::S_GCD: begin
                if (r_gb == 63'd0) begin
                    r_diff <= {1'b0, r_r} - {1'b0, r_orr};
                end else if (div_done) begin
                    r_ga <= r_gb;
                    r_gb <= div_rem[62:0];
                end
            end
            cmt_pkg::S_CHK: if (div_done && bad) r_status <= cmt_pkg::ST_CONTRA;
            cmt_pkg::S_RDC: if (div_done) r_red <= div_q[62:0];
            cmt_pkg::S_OVF: begin
                if (div_done && ({1'b0, r_om} > div_q)) r_status <= cmt_pkg::ST_LCM_OVF;
            end
            cmt_pkg::S_STP: if (div_done) r_step <= div_q[62:0];
            cmt_pkg::S_NM: begin
                if (mul_done) begin
                    r_nm <= mul_p[62:0];
                    r_k  <= 63'd0;
                end
            end
            cmt_pkg::S_DG:  if (div_done) r_dgx <= dgx_val;
            cmt_pkg::S_DGR: if (div_done) r_dg <= dg_val;
            cmt_pkg::S_INV0: begin
                if (div_done) begin
                    r_r1 <= div_rem[62:0];
                    r_r0 <= r_red;
                    r_t0 <= 63'd0;
                    r_t1 <= 63'd1;
                end
            end
            cmt_pkg::S_INVD: begin
                if (r_r1 == 63'd0) begin
                    if (r_r0 != 63'd1) r_status <= cmt_pkg::ST_NO_INV;
                end else if (div_done) begin
                    r_qi <= (div_q[62:0] == r_red) ? 63'd0 : div_q[62:0];
                    r_r2 <= div_rem[62:0];
                end
            end
            cmt_pkg::S_INVM: begin
                if (mul_done) begin
                    r_r0 <= r_r1;
                    r_r1 <= r_r2;
                    r_t0 <= r_t1;
                    r_t1 <= t2;
                end
            end
            cmt_pkg::S_K: if (mul_done) r_k <= mul_p[62:0];
            cmt_pkg::S_MRG: begin
                if (mul_done) begin
                    if (changed) begin
                        r_status <= cmt_pkg::ST_CHANGED;
                        r_pm     <= r_nm;
                        r_pr     <= merged;
                    end else begin
                        r_status <= cmt_pkg::ST_SAME;
                    end
                end
            end
            cmt_pkg::S_OUT: begin
                r_res <= '{status: r_status, stored_modulus: r_pm,
                           stored_residue: r_pr, contradiction: r_flag};
            end
            default: begin
                r_res <= r_res;
            end
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_res;

    cmt_ram #(
        .WIDTH (126),
        .DEPTH (NUM_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    cmt_divu u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_n     (div_n),
        .i_d     (div_d),
        .o_done  (div_done),
        .o_q     (div_q),
        .o_rem   (div_rem)
    );

    cmt_mulmod u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_m     (mul_m),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

`ifndef SYNTHESIS
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("result strobe longer than one cycle");
    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(div_start && mul_start))
        else $error("divider and multiplier started together");
    a_first_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && (r_res.status == cmt_pkg::ST_FIRST)) |-> (r_res.stored_modulus != '0))
        else $error("first set with zero modulus");
    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cmt_pkg::S_CLEAR) |-> !i_valid)
        else $error("word queued during table clear");
`endif

endmodule

// File: sv/congruence_merge_table.sv
`timescale 1ns / 1ps
// top level of the congruence merge table
//
// Usage: drive i_cmd and raise i_start; the word is taken at a rising edge
// with i_start high and o_busy low. The front queues up to two words; the
// merge engine handles one at a time and gives exactly one result per word
// on o_result, with o_done high for that single cycle. Results come in
// order. The receiver cannot stall: a result must be taken when shown.
// A merge runs each step on one shared divider or modular multiplier:
// the reduction, one division per gcd step, four more divisions and two
// multiplies; when m / g is not one, three more divisions, one more
// multiply, and one division plus one multiply per inverse step.
// Reset: synchronous active low; afterwards the slot table is cleared one
// entry per cycle, every slot in turn, with o_busy high.
module congruence_merge_table #(
    parameter int NUM_SLOTS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  cmt_pkg::t_cmd     i_cmd,
    output logic              o_busy,
    output logic              o_done,
    output cmt_pkg::t_result  o_result
);

    cmt_pkg::t_back_stat stat;
    cmt_pkg::t_qent      ent;
    logic                ent_valid;

    cmt_front #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_cmd   (i_cmd),
        .o_busy  (o_busy),
        .i_stat  (stat),
        .o_valid (ent_valid),
        .o_ent   (ent)
    );

    cmt_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (ent_valid),
        .i_ent    (ent),
        .o_stat   (stat),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule
